// ----- rtl/fat16cc_pkg.sv -----
// Package for the FAT16 cluster chain manager: action and status codes,
// FAT16 entry marks and configuration register indexes.
// No dependencies; used by fat16cc_ram and fat16_cluster_chain_manager.
package fat16cc_pkg;

    localparam int ENTRY_W = 16;

    // Request actions. Codes above ACT_FREE behave as a read.
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_ALLOC  = 3'd2;
    localparam logic [2:0] ACT_EXTEND = 3'd3;
    localparam logic [2:0] ACT_FREE   = 3'd4;

    // Result status codes.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_BROKEN  = 3'd2;
    localparam logic [2:0] STAT_RANGE   = 3'd3;
    localparam logic [2:0] STAT_OVERRUN = 3'd4;

    // FAT16 entry marks.
    localparam logic [ENTRY_W-1:0] MARK_RESERVED = 16'hFFF0;
    localparam logic [ENTRY_W-1:0] MARK_END      = 16'hFFF8;
    localparam logic [ENTRY_W-1:0] MARK_EOC      = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE    = 16'h0000;

    // Geometry constants.
    localparam int SECTOR_SHIFT = 9;   // 512-byte sectors
    localparam int DIRENT_SHIFT = 5;   // 32-byte directory entries
    localparam logic [16:0] FIRST_DATA_CLUSTER = 17'd2;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_SPC = 2'd0;
    localparam logic [1:0] CFG_REC = 2'd1;
    localparam logic [1:0] CFG_RDS = 2'd2;
    localparam logic [1:0] CFG_FSI = 2'd3;

    localparam logic [7:0]  SPC_RESET = 8'd4;
    localparam logic [15:0] REC_RESET = 16'd512;
    localparam logic [15:0] RDS_RESET = 16'd0;
    localparam logic [15:0] FSI_RESET = 16'd3;

endpackage

// ----- rtl/fat16cc_ram.sv -----
// Simple dual-port table memory for the FAT16 cluster chain manager.
// One write and one registered read per cycle; a read of the address written
// in the same cycle returns the new data. Depends on fat16cc_pkg.
module fat16cc_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [ADDR_W-1:0]               waddr,
    input  logic [fat16cc_pkg::ENTRY_W-1:0] wdata,
    input  logic                            re,
    input  logic [ADDR_W-1:0]               raddr,
    output logic [fat16cc_pkg::ENTRY_W-1:0] rdata
);

    logic [fat16cc_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [fat16cc_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Forward the write data when a read hits the entry being written.
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fat16_cluster_chain_manager.sv -----
// FAT16 cluster chain manager: top level with the request state machine,
// the table memory and the byte location arithmetic.
// Depends on fat16cc_pkg and fat16cc_ram.
//
// Usage: requests enter on the s_ channel (s_valid/s_ready) with an action,
// a cluster and an entry value; each request gives exactly one result on the
// m_ channel (m_valid/m_ready). Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata while no request is in flight.
// Requests are handled one at a time. After acceptance a read, write or chain
// step passes the fetch, multiply and sum states, and a request off the table
// or a free from an end mark goes straight to multiply and sum; an allocation
// scans the table entries from the search start before multiply and sum, an
// extend adds the entry fetch before its scan and the link write after it, and
// a free clears the first chain entry in the fetch state and each further one in
// the walk state. The next request is accepted in the cycle after the result is
// loaded. The table memory gives one read and one write per cycle.
// After reset the block sweeps the table to zero, one entry per cycle, over all
// TABLE_ENTRIES entries; s_ready stays low during the sweep while configuration
// writes are taken. The result sits in an output register: while the receiver
// stalls, the next request is accepted and worked on, and it waits at the end
// until the output register is free.
module fat16_cluster_chain_manager #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [15:0] s_cluster,
    input  logic [15:0] s_entry_value,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_result_cluster,
    output logic [15:0] m_read_value,
    output logic [16:0] m_freed_count,
    output logic [31:0] m_byte_location
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam logic [16:0] NUM_ENTRIES = 17'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_WALK,
        ST_SCAN,
        ST_LINK,
        ST_MUL,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [7:0]  spc_reg;
    logic [15:0] rec_reg, rds_reg, fsi_reg;

    // Request and working registers
    logic [2:0]  act_reg, act_next;
    logic [15:0] cl_reg, cl_next;
    logic [15:0] val_reg, val_next;
    logic [15:0] cur_reg, cur_next;
    logic [16:0] scan_idx_reg, scan_idx_next;
    logic        chk_valid_reg, chk_valid_next;
    logic [15:0] chk_idx_reg, chk_idx_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] res_reg, res_next;
    logic [15:0] rd_reg, rd_next;
    logic [16:0] freed_reg, freed_next;
    logic [22:0] prod_reg, prod_next;

    // Output registers
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [15:0] m_res_reg, m_res_next;
    logic [15:0] m_rd_reg, m_rd_next;
    logic [16:0] m_freed_reg, m_freed_next;
    logic [31:0] m_loc_reg, m_loc_next;

    // Memory ports
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata, mem_q;

    logic [16:0]        scan_start;
    logic               s_in_table;
    logic               free_empty;
    logic               do_walk;
    logic signed [16:0] cl_off;
    logic signed [8:0]  spc_s;
    logic signed [25:0] prod_full;
    logic [31:0]        loc_sum;

    fat16cc_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // Entries 0 and 1 are reserved, so the search never starts below 2.
    assign scan_start = (fsi_reg < 16'd2) ? fat16cc_pkg::FIRST_DATA_CLUSTER : {1'b0, fsi_reg};
    assign s_in_table = {1'b0, s_cluster} < NUM_ENTRIES;
    assign free_empty = (cl_reg == fat16cc_pkg::ENTRY_FREE)
                     || (cl_reg >= fat16cc_pkg::MARK_RESERVED);
    assign do_walk = (state_reg == ST_WALK)
                  || ((state_reg == ST_FETCH) && (act_reg == fat16cc_pkg::ACT_FREE)
                      && !free_empty);

    // (cluster - 2) * sectors_per_cluster, kept to the bits that survive the
    // shift by the sector size modulo 2^32.
    assign cl_off    = $signed({1'b0, res_reg} - fat16cc_pkg::FIRST_DATA_CLUSTER);
    assign spc_s     = $signed({1'b0, spc_reg});
    assign prod_full = cl_off * spc_s;
    assign loc_sum   = {prod_reg, 9'b0}
                     + {11'b0, rec_reg, 5'b0}
                     + {7'b0, rds_reg, 9'b0};

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        cl_next        = cl_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        rd_next        = rd_reg;
        freed_next     = freed_reg;
        prod_next      = prod_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_res_next     = m_res_reg;
        m_rd_next      = m_rd_reg;
        m_freed_next   = m_freed_reg;
        m_loc_next     = m_loc_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg[ADDR_W-1:0];
        mem_wdata      = fat16cc_pkg::ENTRY_FREE;
        mem_re         = 1'b0;
        mem_raddr      = s_cluster[ADDR_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = scan_idx_reg[ADDR_W-1:0];
                scan_idx_next = scan_idx_reg + 17'd1;
                if (scan_idx_reg == NUM_ENTRIES - 17'd1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    act_next    = s_action;
                    cl_next     = s_cluster;
                    val_next    = s_entry_value;
                    cur_next    = s_cluster;
                    freed_next  = '0;
                    status_next = fat16cc_pkg::STAT_OK;
                    res_next    = s_cluster;
                    rd_next     = '0;
                    if (s_action == fat16cc_pkg::ACT_ALLOC) begin
                        scan_idx_next  = scan_start;
                        chk_valid_next = 1'b0;
                        state_next     = ST_SCAN;
                    end else if (s_in_table) begin
                        mem_re     = 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        // A free from an end mark is an empty chain even off the table.
                        if (!((s_action == fat16cc_pkg::ACT_FREE)
                              && (s_cluster >= fat16cc_pkg::MARK_RESERVED))) begin
                            status_next = fat16cc_pkg::STAT_RANGE;
                        end
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FETCH: begin
                rd_next = mem_q;
                case (act_reg)
                    fat16cc_pkg::ACT_WRITE: begin
                        mem_we     = 1'b1;
                        mem_waddr  = cl_reg[ADDR_W-1:0];
                        mem_wdata  = val_reg;
                        state_next = ST_MUL;
                    end
                    fat16cc_pkg::ACT_EXTEND: begin
                        if (mem_q >= fat16cc_pkg::MARK_END) begin
                            scan_idx_next  = scan_start;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end else if ((mem_q == fat16cc_pkg::ENTRY_FREE)
                                     || (mem_q >= fat16cc_pkg::MARK_RESERVED)) begin
                            status_next = fat16cc_pkg::STAT_BROKEN;
                            state_next  = ST_MUL;
                        end else begin
                            res_next = mem_q;
                            if ({1'b0, mem_q} >= NUM_ENTRIES) begin
                                status_next = fat16cc_pkg::STAT_RANGE;
                            end
                            state_next = ST_MUL;
                        end
                    end
                    fat16cc_pkg::ACT_FREE: begin
                        // A chain walk is handled below; an empty chain ends here.
                        if (free_empty) begin
                            state_next = ST_MUL;
                        end
                    end
                    default: begin
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_WALK: begin
                // Walk steps are handled below.
            end
            ST_SCAN: begin
                // Reads are issued one entry ahead of the check of returned data.
                if (chk_valid_reg && (mem_q == fat16cc_pkg::ENTRY_FREE)) begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_reg[ADDR_W-1:0];
                    mem_wdata = fat16cc_pkg::MARK_EOC;
                    res_next  = chk_idx_reg;
                    if (act_reg == fat16cc_pkg::ACT_EXTEND) begin
                        state_next = ST_LINK;
                    end else begin
                        state_next = ST_MUL;
                    end
                end else if (!chk_valid_reg && (scan_idx_reg >= NUM_ENTRIES)) begin
                    status_next = fat16cc_pkg::STAT_FULL;
                    if (act_reg == fat16cc_pkg::ACT_ALLOC) begin
                        res_next = '0;
                    end else begin
                        res_next = cl_reg;
                    end
                    state_next = ST_MUL;
                end else if (scan_idx_reg < NUM_ENTRIES) begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_idx_reg[ADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[15:0];
                    scan_idx_next  = scan_idx_reg + 17'd1;
                end else begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_LINK: begin
                mem_we     = 1'b1;
                mem_waddr  = cl_reg[ADDR_W-1:0];
                mem_wdata  = res_reg;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = prod_full[22:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_res_next    = res_reg;
                    m_rd_next     = rd_reg;
                    m_freed_next  = freed_reg;
                    m_loc_next    = loc_sum;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // One chain step per cycle: clear the current entry and read the next
        // link in the same cycle. The memory forwards a self-referencing link.
        if (do_walk) begin
            if (mem_q == fat16cc_pkg::ENTRY_FREE) begin
                status_next = fat16cc_pkg::STAT_BROKEN;
                state_next  = ST_MUL;
            end else if (freed_reg >= NUM_ENTRIES) begin
                status_next = fat16cc_pkg::STAT_OVERRUN;
                state_next  = ST_MUL;
            end else begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[ADDR_W-1:0];
                mem_wdata  = fat16cc_pkg::ENTRY_FREE;
                freed_next = freed_reg + 17'd1;
                cur_next   = mem_q;
                if (mem_q >= fat16cc_pkg::MARK_RESERVED) begin
                    state_next = ST_MUL;
                end else if ({1'b0, mem_q} >= NUM_ENTRIES) begin
                    status_next = fat16cc_pkg::STAT_RANGE;
                    state_next  = ST_MUL;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = mem_q[ADDR_W-1:0];
                    state_next = ST_WALK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            spc_reg       <= fat16cc_pkg::SPC_RESET;
            rec_reg       <= fat16cc_pkg::REC_RESET;
            rds_reg       <= fat16cc_pkg::RDS_RESET;
            fsi_reg       <= fat16cc_pkg::FSI_RESET;
        end else begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    fat16cc_pkg::CFG_SPC: spc_reg <= cfg_wdata[7:0];
                    fat16cc_pkg::CFG_REC: rec_reg <= cfg_wdata;
                    fat16cc_pkg::CFG_RDS: rds_reg <= cfg_wdata;
                    fat16cc_pkg::CFG_FSI: fsi_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        cl_reg       <= cl_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        chk_idx_reg  <= chk_idx_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        rd_reg       <= rd_next;
        freed_reg    <= freed_next;
        prod_reg     <= prod_next;
        m_status_reg <= m_status_next;
        m_res_reg    <= m_res_next;
        m_rd_reg     <= m_rd_next;
        m_freed_reg  <= m_freed_next;
        m_loc_reg    <= m_loc_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_cluster = m_res_reg;
    assign m_read_value     = m_rd_reg;
    assign m_freed_count    = m_freed_reg;
    assign m_byte_location  = m_loc_reg;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for fat16_cluster_chain_manager: a scoreboard class keeps its own
// copy of the cluster table and registers, tasks drive requests and config, always blocks results.
// Depends on fat16cc_pkg and the fat16_cluster_chain_manager RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TBL_ENTRIES  = 4096;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 4;
    localparam int PHASE_ITEMS  = 150;
    localparam int RAND_PHASES  = 5;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT   = 40000;
    localparam int LIVE_MAX     = 48;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] res;
        logic [15:0] rd;
        logic [16:0] freed;
        logic [31:0] loc;
    } chain_result_t;

    class chain_scoreboard #(int ENTRIES = 4096);
        logic [15:0]   fat [ENTRIES];
        logic [7:0]    spc;
        logic [15:0]   rec;
        logic [15:0]   rds;
        logic [15:0]   fsi;
        chain_result_t expected_q[$];
        int            errors;
        int            checked;
        int            act_seen [8];
        int            stat_seen [8];
        int            max_freed;

        function new();
            for (int i = 0; i < ENTRIES; i++) fat[i] = fat16cc_pkg::ENTRY_FREE;
            spc = fat16cc_pkg::SPC_RESET;
            rec = fat16cc_pkg::REC_RESET;
            rds = fat16cc_pkg::RDS_RESET;
            fsi = fat16cc_pkg::FSI_RESET;
            errors = 0;
            checked = 0;
            max_freed = 0;
            for (int i = 0; i < 8; i++) begin
                act_seen[i] = 0;
                stat_seen[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                fat16cc_pkg::CFG_SPC: spc = data[7:0];
                fat16cc_pkg::CFG_REC: rec = data;
                fat16cc_pkg::CFG_RDS: rds = data;
                fat16cc_pkg::CFG_FSI: fsi = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] byte_addr(logic [15:0] c);
            logic [31:0] off;
            off = ({16'd0, c} - 32'd2) * ({24'd0, spc} << fat16cc_pkg::SECTOR_SHIFT);
            return off + ({16'd0, rec} << fat16cc_pkg::DIRENT_SHIFT)
                       + ({16'd0, rds} << fat16cc_pkg::SECTOR_SHIFT);
        endfunction

        // Entries 0 and 1 are reserved, so the search never starts below 2.
        function bit first_free(output int found);
            int i;
            i = (fsi < 2) ? 2 : fsi;
            for (; i < ENTRIES; i++) begin
                if (fat[i] == fat16cc_pkg::ENTRY_FREE) begin
                    found = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function chain_result_t note_request(logic [2:0] act, logic [15:0] cl,
                                             logic [15:0] val);
            chain_result_t r;
            bit            in_tbl;
            int            nc;
            int            cur;
            logic [15:0]   nxt;
            in_tbl   = (cl < ENTRIES);
            r.status = fat16cc_pkg::STAT_OK;
            r.res    = cl;
            r.rd     = in_tbl ? fat[cl] : fat16cc_pkg::ENTRY_FREE;
            r.freed  = '0;
            case (act)
                fat16cc_pkg::ACT_WRITE: begin
                    if (in_tbl) fat[cl] = val;
                    else r.status = fat16cc_pkg::STAT_RANGE;
                end
                fat16cc_pkg::ACT_ALLOC: begin
                    r.rd = fat16cc_pkg::ENTRY_FREE;
                    if (first_free(nc)) begin
                        fat[nc] = fat16cc_pkg::MARK_EOC;
                        r.res = 16'(nc);
                    end else begin
                        r.status = fat16cc_pkg::STAT_FULL;
                        r.res = '0;
                    end
                end
                fat16cc_pkg::ACT_EXTEND: begin
                    if (!in_tbl) begin
                        r.status = fat16cc_pkg::STAT_RANGE;
                    end else if (r.rd >= fat16cc_pkg::MARK_END) begin
                        if (first_free(nc)) begin
                            fat[cl] = 16'(nc);
                            fat[nc] = fat16cc_pkg::MARK_EOC;
                            r.res = 16'(nc);
                        end else begin
                            r.status = fat16cc_pkg::STAT_FULL;
                        end
                    end else if (r.rd == fat16cc_pkg::ENTRY_FREE
                                 || r.rd >= fat16cc_pkg::MARK_RESERVED) begin
                        r.status = fat16cc_pkg::STAT_BROKEN;
                    end else begin
                        r.res = r.rd;
                        if (r.rd >= ENTRIES) r.status = fat16cc_pkg::STAT_RANGE;
                    end
                end
                fat16cc_pkg::ACT_FREE: begin
                    // A chain that starts at zero or at a mark is empty.
                    if (cl != 0 && cl < fat16cc_pkg::MARK_RESERVED) begin
                        cur = cl;
                        while (cur < fat16cc_pkg::MARK_RESERVED) begin
                            if (cur >= ENTRIES) begin
                                r.status = fat16cc_pkg::STAT_RANGE;
                                break;
                            end
                            nxt = fat[cur];
                            if (nxt == fat16cc_pkg::ENTRY_FREE) begin
                                r.status = fat16cc_pkg::STAT_BROKEN;
                                break;
                            end
                            if (r.freed >= ENTRIES) begin
                                r.status = fat16cc_pkg::STAT_OVERRUN;
                                break;
                            end
                            fat[cur] = fat16cc_pkg::ENTRY_FREE;
                            r.freed = r.freed + 1'b1;
                            cur = nxt;
                        end
                    end
                    if (r.freed > max_freed) max_freed = r.freed;
                end
                default: begin
                    // Reads and the unused action codes.
                    if (!in_tbl) r.status = fat16cc_pkg::STAT_RANGE;
                end
            endcase
            r.loc = byte_addr(r.res);
            act_seen[act]++;
            stat_seen[r.status]++;
            expected_q.push_back(r);
            return r;
        endfunction

        task report(string what);
            $display("[%0t] ERROR: %0s", $realtime, what);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp)
                report($sformatf("result %0d: %0s is %0h, expected %0h",
                                 checked, name, got, exp));
        endtask

        task check_result(chain_result_t got);
            chain_result_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("result with status %0h arrived with nothing pending",
                                 got.status));
            end else begin
                exp = expected_q.pop_front();
                compare_field("status", 32'(got.status), 32'(exp.status));
                compare_field("result_cluster", 32'(got.res), 32'(exp.res));
                compare_field("read_value", 32'(got.rd), 32'(exp.rd));
                compare_field("freed_count", 32'(got.freed), 32'(exp.freed));
                compare_field("byte_location", got.loc, exp.loc);
            end
            checked++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action      = fat16cc_pkg::ACT_READ;
    logic [15:0] s_cluster     = '0;
    logic [15:0] s_entry_value = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_result_cluster;
    logic [15:0] m_read_value;
    logic [16:0] m_freed_count;
    logic [31:0] m_byte_location;

    chain_scoreboard #(TBL_ENTRIES) sb;
    int            live_q[$];
    int            items_sent   = 0;
    int            cfg_settings = 0;
    int            idle_cycles  = 0;
    bit            send_calm    = 1'b0;
    bit            hold_req     = 1'b0;
    bit            hold_done    = 1'b0;
    int            hold_left    = 0;
    int            ready_gap    = 0;
    int            rx_pct       = 15;
    int            rx_cycles    = 0;
    chain_result_t got_r;

    fat16_cluster_chain_manager #(
        .TABLE_ENTRIES(TBL_ENTRIES)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_cluster       (s_cluster),
        .s_entry_value   (s_entry_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_cluster(m_result_cluster),
        .m_read_value    (m_read_value),
        .m_freed_count   (m_freed_count),
        .m_byte_location (m_byte_location)
    );

    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_live();
        if (live_q.size() == 0) return 16'($urandom_range(2, 40));
        return 16'(live_q[$urandom_range(live_q.size() - 1)]);
    endfunction

    function automatic logic [15:0] pick_cluster();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 16'($urandom_range(0, 1));
        if (roll < 20) return 16'($urandom_range(TBL_ENTRIES - 1, TBL_ENTRIES));
        if (roll < 25)
            return 16'($urandom_range(fat16cc_pkg::MARK_RESERVED, fat16cc_pkg::MARK_EOC));
        if (roll < 65) return pick_live();
        if (roll < 85) return 16'($urandom_range(2, 300));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return pick_live();
        if (roll < 50)
            return 16'($urandom_range(fat16cc_pkg::MARK_END, fat16cc_pkg::MARK_EOC));
        if (roll < 60)
            return 16'($urandom_range(fat16cc_pkg::MARK_RESERVED, fat16cc_pkg::MARK_END - 1));
        if (roll < 70) return fat16cc_pkg::ENTRY_FREE;
        if (roll < 80)
            return 16'($urandom_range(TBL_ENTRIES, fat16cc_pkg::MARK_RESERVED - 1));
        return 16'($urandom);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    // The upper byte of the sectors-per-cluster write is random and must be ignored.
    task automatic configure(logic [7:0] spc, logic [15:0] rec, logic [15:0] rds,
                             logic [15:0] fsi);
        write_reg(fat16cc_pkg::CFG_SPC, {8'($urandom), spc});
        write_reg(fat16cc_pkg::CFG_REC, rec);
        write_reg(fat16cc_pkg::CFG_RDS, rds);
        write_reg(fat16cc_pkg::CFG_FSI, fsi);
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    task automatic send_request(logic [2:0] act, logic [15:0] cl, logic [15:0] val);
        int            gap;
        chain_result_t exp_r;
        gap = (send_calm || $urandom_range(99) < 45) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_cluster     <= cl;
        s_entry_value <= val;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        exp_r = sb.note_request(act, cl, val);
        items_sent++;
        if ((act == fat16cc_pkg::ACT_ALLOC || act == fat16cc_pkg::ACT_EXTEND)
            && exp_r.status == fat16cc_pkg::STAT_OK) begin
            live_q.push_back(exp_r.res);
            if (live_q.size() > LIVE_MAX) live_q.delete(0);
        end
    endtask

    // Loads a short chain by writes, then frees it, extends it or reads one of its entries.
    task automatic load_chain();
        int          len;
        int          roll;
        logic [15:0] nodes [6];
        logic [15:0] tail_val;
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++) nodes[i] = 16'($urandom_range(2, 300));
        roll = $urandom_range(99);
        if (roll < 50)
            tail_val = 16'($urandom_range(fat16cc_pkg::MARK_END, fat16cc_pkg::MARK_EOC));
        else if (roll < 60)
            tail_val = 16'($urandom_range(fat16cc_pkg::MARK_RESERVED,
                                          fat16cc_pkg::MARK_END - 1));
        else if (roll < 70)
            tail_val = fat16cc_pkg::ENTRY_FREE;
        else if (roll < 85)
            tail_val = 16'($urandom_range(TBL_ENTRIES, fat16cc_pkg::MARK_RESERVED - 1));
        else
            tail_val = nodes[0];
        for (int i = 0; i < len - 1; i++)
            send_request(fat16cc_pkg::ACT_WRITE, nodes[i], nodes[i + 1]);
        send_request(fat16cc_pkg::ACT_WRITE, nodes[len - 1], tail_val);
        roll = $urandom_range(99);
        if (roll < 70)
            send_request(fat16cc_pkg::ACT_FREE, nodes[0], 16'($urandom));
        else if (roll < 90)
            send_request(fat16cc_pkg::ACT_EXTEND, nodes[len - 1], 16'($urandom));
        else
            send_request(fat16cc_pkg::ACT_READ, nodes[$urandom_range(len - 1)],
                         16'($urandom));
    endtask

    task automatic send_random();
        int          roll;
        logic [2:0]  act;
        logic [15:0] cl;
        logic [15:0] val;
        roll = $urandom_range(99);
        val  = 16'($urandom);
        if (roll < 18) begin
            act = fat16cc_pkg::ACT_ALLOC;
            cl  = 16'($urandom);
        end else if (roll < 43) begin
            act = fat16cc_pkg::ACT_EXTEND;
            cl  = ($urandom_range(9) != 0) ? pick_live() : pick_cluster();
        end else if (roll < 57) begin
            act = fat16cc_pkg::ACT_FREE;
            cl  = ($urandom_range(6) != 0) ? pick_live() : pick_cluster();
        end else if (roll < 72) begin
            act = fat16cc_pkg::ACT_WRITE;
            cl  = pick_cluster();
            val = pick_value();
        end else if (roll < 86) begin
            act = fat16cc_pkg::ACT_READ;
            cl  = pick_cluster();
        end else begin
            act = 3'($urandom_range(7));
            cl  = 16'($urandom);
        end
        send_request(act, cl, val);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (ready_gap > 0) begin
            m_ready   <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (rx_pct != 0 && $urandom_range(99) < rx_pct) ready_gap <= pick_gap();
        end
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 256 == 255) begin
            case ($urandom_range(2))
                0:       rx_pct <= 0;
                1:       rx_pct <= 15;
                default: rx_pct <= 50;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got_r.status = m_status;
            got_r.res    = m_result_cluster;
            got_r.rd     = m_read_value;
            got_r.freed  = m_freed_count;
            got_r.loc    = m_byte_location;
            sb.check_result(got_r);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Lowest geometry; a search start below 2 must be raised to 2.
        configure(8'd1, 16'd0, 16'd0, 16'd0);
        send_request(fat16cc_pkg::ACT_READ, 16'd0, 16'd0);
        send_request(fat16cc_pkg::ACT_READ, 16'(TBL_ENTRIES - 1), 16'hFFFF);
        send_request(fat16cc_pkg::ACT_READ, 16'(TBL_ENTRIES), 16'd0);
        send_request(3'd7, 16'hFFFF, 16'd0);
        send_request(3'd5, 16'd1, 16'd0);
        send_request(3'd6, 16'd2, 16'd0);
        send_request(fat16cc_pkg::ACT_ALLOC, 16'd0, 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'd10, fat16cc_pkg::MARK_EOC);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'd10, 16'd0);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'd10, 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'd20, 16'hFFF3);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'd20, 16'd0);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'd21, 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'd22, 16'd5000);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'd22, 16'd0);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'(TBL_ENTRIES), 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'hFFFF, 16'h1234);
        send_request(fat16cc_pkg::ACT_FREE, 16'd0, 16'd0);
        send_request(fat16cc_pkg::ACT_FREE, fat16cc_pkg::MARK_RESERVED, 16'd0);
        send_request(fat16cc_pkg::ACT_FREE, 16'd10, 16'd0);
        send_request(fat16cc_pkg::ACT_FREE, 16'd22, 16'd0);
        send_request(fat16cc_pkg::ACT_FREE, 16'd21, 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'd30, 16'd31);
        send_request(fat16cc_pkg::ACT_FREE, 16'd30, 16'd0);
        send_request(fat16cc_pkg::ACT_FREE, 16'(TBL_ENTRIES), 16'd0);
        send_request(fat16cc_pkg::ACT_WRITE, 16'(TBL_ENTRIES - 1), 16'hFFFF);
        send_request(fat16cc_pkg::ACT_FREE, 16'hFFFF, 16'd0);
        wait_drained();

        // Highest geometry with a full search window at the top of the table.
        configure(8'd128, 16'hFFFF, 16'hFFFF, 16'(TBL_ENTRIES - 3));
        send_request(fat16cc_pkg::ACT_WRITE, 16'(TBL_ENTRIES - 3), fat16cc_pkg::MARK_EOC);
        send_request(fat16cc_pkg::ACT_WRITE, 16'(TBL_ENTRIES - 2), fat16cc_pkg::MARK_EOC);
        send_request(fat16cc_pkg::ACT_WRITE, 16'(TBL_ENTRIES - 1), fat16cc_pkg::MARK_END);
        send_request(fat16cc_pkg::ACT_ALLOC, 16'd0, 16'd0);
        send_request(fat16cc_pkg::ACT_EXTEND, 16'(TBL_ENTRIES - 1), 16'd0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: configure(8'($urandom_range(1, 128)), 16'($urandom), 16'($urandom),
                             16'($urandom_range(2, 40)));
                1: configure(8'($urandom_range(1, 128)), 16'($urandom), 16'($urandom),
                             16'($urandom_range(TBL_ENTRIES - 16, TBL_ENTRIES - 1)));
                2: configure(8'd0, 16'd0, 16'd0, 16'($urandom_range(0, 1)));
                3: configure(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: configure(8'($urandom_range(1, 128)), 16'($urandom),
                                   16'($urandom), 16'($urandom_range(2, TBL_ENTRIES - 1)));
            endcase
            send_calm = ($urandom_range(3) == 0);
            // The first random phase also fills the block behind a stalled receiver.
            if (ph == 0) begin
                send_calm = 1'b1;
                hold_req  = 1'b1;
            end
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 8) load_chain();
                else send_random();
                if (ph == 0 && hold_done && hold_left == 0) send_calm = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $write("Covered %0d results over %0d register settings: read %0d, write %0d,",
               sb.checked, cfg_settings, sb.act_seen[fat16cc_pkg::ACT_READ],
               sb.act_seen[fat16cc_pkg::ACT_WRITE]);
        $display(" allocate %0d, extend %0d, free %0d, unused codes %0d.",
                 sb.act_seen[fat16cc_pkg::ACT_ALLOC], sb.act_seen[fat16cc_pkg::ACT_EXTEND],
                 sb.act_seen[fat16cc_pkg::ACT_FREE],
                 sb.act_seen[5] + sb.act_seen[6] + sb.act_seen[7]);
        $write("Table full %0d, broken chain %0d, out of range %0d,",
               sb.stat_seen[fat16cc_pkg::STAT_FULL], sb.stat_seen[fat16cc_pkg::STAT_BROKEN],
               sb.stat_seen[fat16cc_pkg::STAT_RANGE]);
        $display(" longest free %0d entries, %0d mismatches.", sb.max_freed, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fat16cc_pkg.sv
rtl/fat16cc_ram.sv
rtl/fat16_cluster_chain_manager.sv
dv/tb_top.sv
